// ===== hw/rtl/rk4dho_pkg.sv =====
`default_nettype none

package rk4dho_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 24;
   localparam int OUT_BITS  = 32;
   localparam int COEF_BITS = 31;
   localparam int CNT_BITS  = 16;
   localparam int PROD_BITS = 2 * WORD_BITS;
   localparam int PC_BITS   = 6;
   localparam int ADDR_BITS = 5;
   localparam int IDX_BITS  = 3;

   localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   localparam int DIV6_SHIFT = WORD_BITS + 2;
   localparam logic [PROD_BITS:0] DIV6_RECIP_WIDE =
      (((PROD_BITS+1)'(1) << (WORD_BITS + 1)) + (PROD_BITS+1)'(1)) / (PROD_BITS+1)'(3);
   localparam logic [WORD_BITS-1:0] DIV6_RECIP = DIV6_RECIP_WIDE[WORD_BITS-1:0];

   localparam logic [COEF_BITS-1:0] STIFFNESS_RESET = 31'd8388608;
   localparam logic [COEF_BITS-1:0] DAMPING_RESET   = 31'd0;
   localparam logic [COEF_BITS-1:0] STEP_SIZE_RESET = 31'd5270718;
   localparam logic [OUT_BITS-1:0]  INIT_POS_RESET  = 32'h0100_0000;
   localparam logic [OUT_BITS-1:0]  INIT_VEL_RESET  = 32'h0000_0000;

   localparam logic [IDX_BITS-1:0] REG_STIFFNESS = 3'd0;
   localparam logic [IDX_BITS-1:0] REG_DAMPING   = 3'd1;
   localparam logic [IDX_BITS-1:0] REG_STEP_SIZE = 3'd2;
   localparam logic [IDX_BITS-1:0] REG_INIT_POS  = 3'd3;
   localparam logic [IDX_BITS-1:0] REG_INIT_VEL  = 3'd4;

   typedef enum logic [1:0] {
      SQ_NEXT,
      SQ_SKIP,
      SQ_END
   } seq_type;

   typedef enum logic [2:0] {
      AL_NOP,
      AL_MOV,
      AL_ADD,
      AL_ADD2,
      AL_SUB
   } alu_op_type;

   typedef enum logic [1:0] {
      MU_NONE,
      MU_RND,
      MU_DIV6
   } mul_op_type;

   typedef enum logic [3:0] {
      S_ZERO,
      S_X,
      S_V,
      S_K,
      S_C,
      S_H,
      S_HH,
      S_IX,
      S_IV,
      S_R,
      S_SX,
      S_SV,
      S_XI,
      S_VI,
      S_AVI,
      S_N
   } src_type;

   typedef enum logic [3:0] {
      D_NONE,
      D_X,
      D_V,
      D_SX,
      D_SV,
      D_XI,
      D_VI,
      D_AVI,
      D_N
   } dst_type;

   typedef struct packed {
      seq_type              seq;
      logic [PC_BITS-1:0]   target;
      alu_op_type           alu;
      src_type              alu_a;
      src_type              alu_b;
      dst_type              dst;
      mul_op_type           mul;
      src_type              mul_a;
      src_type              mul_b;
   } uop_type;

   typedef struct packed {
      logic [COEF_BITS-1:0] stiffness;
      logic [COEF_BITS-1:0] damping;
      logic [COEF_BITS-1:0] step_size;
      logic [OUT_BITS-1:0]  init_pos;
      logic [OUT_BITS-1:0]  init_vel;
   } cfg_type;

   localparam logic [PC_BITS-1:0] PC_ZERO = '0;
   localparam logic [PC_BITS-1:0] PC_MAIN = 6'd3;
   localparam logic [PC_BITS-1:0] PC_LAST = 6'd32;

   localparam uop_type UOP_IDLE =
      '{SQ_END, PC_ZERO, AL_NOP, S_ZERO, S_ZERO, D_NONE, MU_NONE, S_ZERO, S_ZERO};

   // A product issued at one step passes through prod_ff and r_ff before it is readable as S_R.
   function automatic uop_type ucode_rom(input logic [PC_BITS-1:0] pc);
      uop_type u;
      unique case (pc)
         6'd0:  u = '{SQ_SKIP, PC_MAIN, AL_NOP, S_ZERO, S_ZERO, D_NONE, MU_NONE, S_ZERO, S_ZERO};
         6'd1:  u = '{SQ_NEXT, PC_ZERO, AL_MOV, S_IX, S_ZERO, D_X, MU_NONE, S_ZERO, S_ZERO};
         6'd2:  u = '{SQ_NEXT, PC_ZERO, AL_MOV, S_IV, S_ZERO, D_V, MU_NONE, S_ZERO, S_ZERO};
         6'd3:  u = '{SQ_NEXT, PC_ZERO, AL_MOV, S_V, S_ZERO, D_SX, MU_RND, S_K, S_X};
         6'd4:  u = '{SQ_NEXT, PC_ZERO, AL_NOP, S_ZERO, S_ZERO, D_NONE, MU_RND, S_C, S_V};
         6'd5:  u = '{SQ_NEXT, PC_ZERO, AL_SUB, S_ZERO, S_R, D_N, MU_RND, S_HH, S_V};
         6'd6:  u = '{SQ_NEXT, PC_ZERO, AL_SUB, S_N, S_R, D_AVI, MU_NONE, S_ZERO, S_ZERO};
         6'd7:  u = '{SQ_NEXT, PC_ZERO, AL_ADD, S_X, S_R, D_XI, MU_RND, S_HH, S_AVI};
         6'd8:  u = '{SQ_NEXT, PC_ZERO, AL_MOV, S_AVI, S_ZERO, D_SV, MU_RND, S_K, S_XI};
         6'd9:  u = '{SQ_NEXT, PC_ZERO, AL_ADD, S_V, S_R, D_VI, MU_NONE, S_ZERO, S_ZERO};
         6'd10: u = '{SQ_NEXT, PC_ZERO, AL_SUB, S_ZERO, S_R, D_N, MU_RND, S_C, S_VI};
         6'd11: u = '{SQ_NEXT, PC_ZERO, AL_ADD2, S_SX, S_VI, D_SX, MU_RND, S_HH, S_VI};
         6'd12: u = '{SQ_NEXT, PC_ZERO, AL_SUB, S_N, S_R, D_AVI, MU_NONE, S_ZERO, S_ZERO};
         6'd13: u = '{SQ_NEXT, PC_ZERO, AL_ADD, S_X, S_R, D_XI, MU_RND, S_HH, S_AVI};
         6'd14: u = '{SQ_NEXT, PC_ZERO, AL_ADD2, S_SV, S_AVI, D_SV, MU_RND, S_K, S_XI};
         6'd15: u = '{SQ_NEXT, PC_ZERO, AL_ADD, S_V, S_R, D_VI, MU_NONE, S_ZERO, S_ZERO};
         6'd16: u = '{SQ_NEXT, PC_ZERO, AL_SUB, S_ZERO, S_R, D_N, MU_RND, S_C, S_VI};
         6'd17: u = '{SQ_NEXT, PC_ZERO, AL_ADD2, S_SX, S_VI, D_SX, MU_RND, S_H, S_VI};
         6'd18: u = '{SQ_NEXT, PC_ZERO, AL_SUB, S_N, S_R, D_AVI, MU_NONE, S_ZERO, S_ZERO};
         6'd19: u = '{SQ_NEXT, PC_ZERO, AL_ADD, S_X, S_R, D_XI, MU_RND, S_H, S_AVI};
         6'd20: u = '{SQ_NEXT, PC_ZERO, AL_ADD2, S_SV, S_AVI, D_SV, MU_RND, S_K, S_XI};
         6'd21: u = '{SQ_NEXT, PC_ZERO, AL_ADD, S_V, S_R, D_VI, MU_NONE, S_ZERO, S_ZERO};
         6'd22: u = '{SQ_NEXT, PC_ZERO, AL_SUB, S_ZERO, S_R, D_N, MU_RND, S_C, S_VI};
         6'd23: u = '{SQ_NEXT, PC_ZERO, AL_ADD, S_SX, S_VI, D_SX, MU_NONE, S_ZERO, S_ZERO};
         6'd24: u = '{SQ_NEXT, PC_ZERO, AL_SUB, S_N, S_R, D_AVI, MU_RND, S_H, S_SX};
         6'd25: u = '{SQ_NEXT, PC_ZERO, AL_ADD, S_SV, S_AVI, D_SV, MU_NONE, S_ZERO, S_ZERO};
         6'd26: u = '{SQ_NEXT, PC_ZERO, AL_MOV, S_R, S_ZERO, D_N, MU_RND, S_H, S_SV};
         6'd27: u = '{SQ_NEXT, PC_ZERO, AL_NOP, S_ZERO, S_ZERO, D_NONE, MU_DIV6, S_N, S_ZERO};
         6'd28: u = '{SQ_NEXT, PC_ZERO, AL_MOV, S_R, S_ZERO, D_AVI, MU_NONE, S_ZERO, S_ZERO};
         6'd29: u = '{SQ_NEXT, PC_ZERO, AL_ADD, S_X, S_R, D_X, MU_DIV6, S_AVI, S_ZERO};
         6'd30: u = '{SQ_NEXT, PC_ZERO, AL_NOP, S_ZERO, S_ZERO, D_NONE, MU_NONE, S_ZERO, S_ZERO};
         6'd31: u = '{SQ_NEXT, PC_ZERO, AL_ADD, S_V, S_R, D_V, MU_NONE, S_ZERO, S_ZERO};
         default: u = UOP_IDLE;
      endcase
      return u;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rk4dho_datapath.sv =====
`default_nettype none

module rk4dho_datapath import rk4dho_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire uop_type              uop,
   input  wire cfg_type              cfg,
   output logic [WORD_BITS-1:0]      position,
   output logic [WORD_BITS-1:0]      velocity
);

   logic [WORD_BITS-1:0] x_ff, v_ff, sx_ff, sv_ff, xi_ff, vi_ff, avi_ff, n_ff;
   logic [WORD_BITS-1:0] r_ff, r_in;
   logic [PROD_BITS-1:0] prod_ff, prod_in;
   logic                 neg_ff, neg_in;
   logic                 div_ff, div_in;

   logic [WORD_BITS-1:0] alu_a, alu_b, alu_res;
   logic [WORD_BITS-1:0] mul_a, mul_b, mag_a, mag_b;
   logic [PROD_BITS:0]   rnd_sum, quot;

   function automatic logic [WORD_BITS-1:0] sat_add(input logic [WORD_BITS-1:0] a,
                                                    input logic [WORD_BITS-1:0] b);
      logic [WORD_BITS:0] s;
      s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
      if (s[WORD_BITS] != s[WORD_BITS-1]) begin
         return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
      end
      return s[WORD_BITS-1:0];
   endfunction

   function automatic logic [WORD_BITS-1:0] sat_sub(input logic [WORD_BITS-1:0] a,
                                                    input logic [WORD_BITS-1:0] b);
      logic [WORD_BITS:0] s;
      s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
      if (s[WORD_BITS] != s[WORD_BITS-1]) begin
         return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
      end
      return s[WORD_BITS-1:0];
   endfunction

   function automatic logic [WORD_BITS-1:0] pick(input src_type s);
      logic [WORD_BITS-1:0] d;
      unique case (s)
         S_ZERO: d = '0;
         S_X:    d = x_ff;
         S_V:    d = v_ff;
         S_K:    d = WORD_BITS'(cfg.stiffness);
         S_C:    d = WORD_BITS'(cfg.damping);
         S_H:    d = WORD_BITS'(cfg.step_size);
         S_HH:   d = WORD_BITS'(cfg.step_size[COEF_BITS-1:1]);
         S_IX:   d = WORD_BITS'(cfg.init_pos);
         S_IV:   d = WORD_BITS'(cfg.init_vel);
         S_R:    d = r_ff;
         S_SX:   d = sx_ff;
         S_SV:   d = sv_ff;
         S_XI:   d = xi_ff;
         S_VI:   d = vi_ff;
         S_AVI:  d = avi_ff;
         S_N:    d = n_ff;
      endcase
      return d;
   endfunction

   always_comb begin
      alu_a = pick(uop.alu_a);
      alu_b = pick(uop.alu_b);
      mul_a = pick(uop.mul_a);
      mul_b = pick(uop.mul_b);
   end

   always_comb begin
      unique case (uop.alu)
         AL_MOV:  alu_res = alu_a;
         AL_ADD:  alu_res = sat_add(alu_a, alu_b);
         AL_ADD2: alu_res = sat_add(sat_add(alu_a, alu_b), alu_b);
         AL_SUB:  alu_res = sat_sub(alu_a, alu_b);
         default: alu_res = alu_a;
      endcase
   end

   always_comb begin
      mag_a = mul_a[WORD_BITS-1] ? (~mul_a + WORD_BITS'(1)) : mul_a;
      mag_b = mul_b[WORD_BITS-1] ? (~mul_b + WORD_BITS'(1)) : mul_b;
      div_in = (uop.mul == MU_DIV6);
      if (div_in) begin
         prod_in = PROD_BITS'(mag_a + WORD_BITS'(3)) * PROD_BITS'(DIV6_RECIP);
         neg_in  = mul_a[WORD_BITS-1];
      end else begin
         prod_in = PROD_BITS'(mag_a) * PROD_BITS'(mag_b);
         neg_in  = mul_a[WORD_BITS-1] ^ mul_b[WORD_BITS-1];
      end
   end

   always_comb begin
      rnd_sum = {1'b0, prod_ff} + ((PROD_BITS+1)'(1) << (FRAC_BITS - 1));
      quot    = div_ff ? ({1'b0, prod_ff} >> DIV6_SHIFT) : (rnd_sum >> FRAC_BITS);
      if (quot > (PROD_BITS+1)'(WORD_MAX)) begin
         r_in = neg_ff ? WORD_MIN : WORD_MAX;
      end else if (neg_ff) begin
         r_in = ~quot[WORD_BITS-1:0] + WORD_BITS'(1);
      end else begin
         r_in = quot[WORD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      neg_ff  <= neg_in;
      div_ff  <= div_in;
      r_ff    <= r_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= WORD_BITS'(INIT_POS_RESET);
         v_ff <= WORD_BITS'(INIT_VEL_RESET);
      end else begin
         unique case (uop.dst)
            D_NONE: ;
            D_X:    x_ff   <= alu_res;
            D_V:    v_ff   <= alu_res;
            D_SX:   sx_ff  <= alu_res;
            D_SV:   sv_ff  <= alu_res;
            D_XI:   xi_ff  <= alu_res;
            D_VI:   vi_ff  <= alu_res;
            D_AVI:  avi_ff <= alu_res;
            D_N:    n_ff   <= alu_res;
            default: ;
         endcase
      end
   end

   assign position = x_ff;
   assign velocity = v_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/rk4_damped_oscillator_step_core.sv =====
`default_nettype none

// Damped mass-spring oscillator, one fourth-order Runge-Kutta step per word.
// Each word accepted on the req channel is one time tick. If req_restart is
// set, the initial position and velocity registers are reloaded and the step
// count cleared first. The rsp word carries position and velocity in signed
// Q8.24 and the number of steps since the last restart.
// Stiffness, damping, step size and the initial state are written through
// the csr port (byte addresses 0, 4, 8, 12, 16). The user must write them
// only while the block is idle; the block itself does not enforce this.
// The four dependent stages run as a microprogram on one shared 32x32
// multiplier with a rounding pipeline through prod_ff and r_ff and one
// saturating ALU. req_ready returns in the same cycle that rsp_valid rises,
// but a new word is taken only once the last one has finished.
// If the receiver stalls, the result waits in the output register and the
// next word is computed; it is held at its last step until rsp is free.
// After reset the state is position 1.0, velocity 0 and step count 0, and
// the registers hold their documented defaults.
module rk4_damped_oscillator_step_core import rk4dho_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_restart,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic signed [OUT_BITS-1:0]  rsp_position_out,
   output logic signed [OUT_BITS-1:0]  rsp_velocity_out,
   output logic [CNT_BITS-1:0]         rsp_step_index,
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [ADDR_BITS-1:0]   csr_paddr,
   input  wire logic [31:0]            csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);

   cfg_type              cfg_ff, cfg_in;
   logic                 busy_ff, busy_in;
   logic [PC_BITS-1:0]   pc_ff, pc_in;
   logic                 restart_ff, restart_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OUT_BITS-1:0]  rsp_pos_ff, rsp_pos_in;
   logic [OUT_BITS-1:0]  rsp_vel_ff, rsp_vel_in;
   logic [CNT_BITS-1:0]  rsp_idx_ff, rsp_idx_in;

   uop_type              uop_rom, uop_act;
   logic                 end_fire;
   logic                 csr_wr;
   logic [IDX_BITS-1:0]  csr_idx;
   logic [WORD_BITS-1:0] dp_position, dp_velocity;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[ADDR_BITS-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            REG_STIFFNESS: cfg_in.stiffness = csr_pwdata[COEF_BITS-1:0];
            REG_DAMPING:   cfg_in.damping   = csr_pwdata[COEF_BITS-1:0];
            REG_STEP_SIZE: cfg_in.step_size = csr_pwdata[COEF_BITS-1:0];
            REG_INIT_POS:  cfg_in.init_pos  = csr_pwdata[OUT_BITS-1:0];
            REG_INIT_VEL:  cfg_in.init_vel  = csr_pwdata[OUT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_STIFFNESS: csr_prdata = 32'(cfg_ff.stiffness);
         REG_DAMPING:   csr_prdata = 32'(cfg_ff.damping);
         REG_STEP_SIZE: csr_prdata = 32'(cfg_ff.step_size);
         REG_INIT_POS:  csr_prdata = 32'(cfg_ff.init_pos);
         REG_INIT_VEL:  csr_prdata = 32'(cfg_ff.init_vel);
         default:       csr_prdata = '0;
      endcase
   end

   assign uop_rom  = ucode_rom(pc_ff);
   assign uop_act  = busy_ff ? uop_rom : UOP_IDLE;
   assign end_fire = busy_ff && (uop_rom.seq == SQ_END) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      busy_in    = busy_ff;
      pc_in      = pc_ff;
      restart_in = restart_ff;
      count_in   = count_ff;
      if (!busy_ff) begin
         if (req_valid) begin
            busy_in    = 1'b1;
            pc_in      = PC_ZERO;
            restart_in = req_restart;
         end
      end else begin
         unique case (uop_rom.seq)
            SQ_NEXT: pc_in = pc_ff + PC_BITS'(1);
            SQ_SKIP: pc_in = restart_ff ? (pc_ff + PC_BITS'(1)) : uop_rom.target;
            SQ_END: begin
               if (end_fire) begin
                  busy_in  = 1'b0;
                  count_in = (restart_ff ? '0 : count_ff) + CNT_BITS'(1);
               end
            end
            default: pc_in = pc_ff;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = end_fire || (rsp_valid_ff && !rsp_ready);
      rsp_pos_in   = rsp_pos_ff;
      rsp_vel_in   = rsp_vel_ff;
      rsp_idx_in   = rsp_idx_ff;
      if (end_fire) begin
         rsp_pos_in = dp_position[OUT_BITS-1:0];
         rsp_vel_in = dp_velocity[OUT_BITS-1:0];
         rsp_idx_in = count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '{STIFFNESS_RESET, DAMPING_RESET, STEP_SIZE_RESET,
                           INIT_POS_RESET, INIT_VEL_RESET};
         busy_ff      <= 1'b0;
         pc_ff        <= PC_ZERO;
         restart_ff   <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         restart_ff   <= restart_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pos_ff <= rsp_pos_in;
      rsp_vel_ff <= rsp_vel_in;
      rsp_idx_ff <= rsp_idx_in;
   end

   rk4dho_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .uop      (uop_act),
      .cfg      (cfg_ff),
      .position (dp_position),
      .velocity (dp_velocity)
   );

   assign req_ready        = !busy_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_position_out = $signed(rsp_pos_ff);
   assign rsp_velocity_out = $signed(rsp_vel_ff);
   assign rsp_step_index   = rsp_idx_ff;

   a_start_at_zero: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (busy_ff && pc_ff == PC_ZERO))
      else $error("Sequencer did not start at the first step.");

   a_result_from_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(busy_ff && uop_rom.seq == SQ_END))
      else $error("Result appeared without the program reaching its end.");

   a_pc_in_program: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (pc_ff <= PC_LAST))
      else $error("Step counter ran past the program.");

endmodule

`default_nettype wire
